[rtl/buffer_pool_sizing_policy_unit_assert.svh]
// Assertion macros used by the buffer pool sizing policy checker.
`ifndef BUFFER_POOL_SIZING_POLICY_UNIT_ASSERT_SVH
`define BUFFER_POOL_SIZING_POLICY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BPSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buffer pool sizing policy check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BPSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("buffer pool sizing policy check failed");

`endif

[rtl/bpsp_pkg.sv]
// Package with the command and status codes and fixed constants of the pool sizing policy.
package bpsp_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic [1:0] CMD_COLLECT = 2'd3;

	// Status codes of a result item.
	localparam logic [2:0] STATUS_REUSED = 3'd0;
	localparam logic [2:0] STATUS_NEW    = 3'd1;
	localparam logic [2:0] STATUS_FRAG   = 3'd2;
	localparam logic [2:0] STATUS_KEPT   = 3'd3;
	localparam logic [2:0] STATUS_DONE   = 3'd4;
	localparam logic [2:0] STATUS_SAT    = 3'd5;

	// Width of the count fields on the result ports.
	localparam int OUT_W = 16;

	// Smoothing shifts of the slow and fast averages.
	localparam int SLOW_SHIFT = 4;
	localparam int FAST_SHIFT = 1;

	// Shift that gives the held share compared against on a tick.
	localparam int HELD_SHARE_SHIFT = 4;

	// Oversize streak counter and the reset value of its limit register.
	localparam logic [7:0] STREAK_MAX     = 8'd255;
	localparam logic [7:0] OVERSIZE_RESET = 8'd30;

endpackage

[rtl/bpsp_ema.sv]
// One step of an exponential moving average: avg - avg/2^SH + sample/2^SH.
module bpsp_ema #(
	parameter int W  = 21,
	parameter int SH = 1
) (
	input  logic [W-1:0] avg,
	input  logic [W-1:0] sample,
	output logic [W-1:0] avg_next
);

	logic [W:0] sum;

	// The result never exceeds the larger of avg and sample, so the top bit drops.
	always_comb begin
		sum      = {1'b0, avg} - {1'b0, (avg >> SH)} + {1'b0, (sample >> SH)};
		avg_next = sum[W-1:0];
	end

endmodule

[rtl/buffer_pool_sizing_policy_unit.sv]
// Top level of the buffer pool sizing policy: counts, usage averages and collection decisions.
//
// The block takes one command item in every clock cycle; busy is always low. An item accepted
// on start is captured in an input register, and its result goes through the result register
// to the result ports, marked by done for exactly one cycle, with all count, average and
// collection logic between the two registers. The receiver cannot hold results off, so each
// result must be taken in the cycle it is shown. The user must write the oversize limit
// register through cfg_we and cfg_wdata only while no item is in flight; the block does not
// enforce this. Counts saturate at 2^COUNT_BITS-1; the count ports show their low 16 bits.
module buffer_pool_sizing_policy_unit
	import bpsp_pkg::*;
#(
	parameter int COUNT_BITS = 16,
	parameter int AVG_SHIFT  = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic                fragment,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	output logic                done,
	output logic [2:0]          status,
	output logic [OUT_W-1:0]    release_count,
	output logic [OUT_W-1:0]    allocated_count,
	output logic [OUT_W-1:0]    held_count,
	output logic                gc_wanted
);

	localparam int CW = COUNT_BITS;
	localparam int AW = COUNT_BITS + AVG_SHIFT;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	// Input register.
	logic       start_s1;
	logic [1:0] cmd_s1;
	logic       frag_s1;

	// Policy state.
	logic [CW-1:0] alloc_q, held_q, run_q, longest_q, peak_q;
	logic [AW-1:0] us_avg_q, uf_avg_q, hs_avg_q, hf_avg_q, run_avg_q;
	logic [7:0]    streak_q;
	logic          gc_q;
	logic [7:0]    limit_q;

	// Next state and result.
	logic [CW-1:0] alloc_n, held_n, run_n, longest_n, peak_n;
	logic [AW-1:0] us_avg_n, uf_avg_n, hs_avg_n, hf_avg_n, run_avg_n;
	logic [7:0]    streak_n;
	logic          gc_n;
	logic [2:0]    status_n;
	logic [CW-1:0] release_n;

	// Averages stepped with the current samples.
	logic [CW-1:0] used;
	logic [AW-1:0] used_smp, held_smp, run_smp;
	logic [AW-1:0] us_step, uf_step, hs_step, hf_step, run_step;

	assign busy = 1'b0;

	// Capture each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd;
		frag_s1 <= fragment;
	end

	// Buffers in use, clamped at zero.
	assign used     = (alloc_q > held_q) ? (alloc_q - held_q) : '0;
	assign used_smp = {used, {AVG_SHIFT{1'b0}}};
	assign held_smp = {held_q, {AVG_SHIFT{1'b0}}};
	assign run_smp  = {longest_q, {AVG_SHIFT{1'b0}}};

	bpsp_ema #(.W(AW), .SH(SLOW_SHIFT)) u_used_slow (
		.avg(us_avg_q), .sample(used_smp), .avg_next(us_step));
	bpsp_ema #(.W(AW), .SH(FAST_SHIFT)) u_used_fast (
		.avg(uf_avg_q), .sample(used_smp), .avg_next(uf_step));
	bpsp_ema #(.W(AW), .SH(SLOW_SHIFT)) u_held_slow (
		.avg(hs_avg_q), .sample(held_smp), .avg_next(hs_step));
	bpsp_ema #(.W(AW), .SH(FAST_SHIFT)) u_held_fast (
		.avg(hf_avg_q), .sample(held_smp), .avg_next(hf_step));
	bpsp_ema #(.W(AW), .SH(FAST_SHIFT)) u_run_fast (
		.avg(run_avg_q), .sample(run_smp), .avg_next(run_step));

	// Tick terms: target from the stepped averages.
	logic [CW-1:0] tk_ema, tk_us, tk_uf;
	logic [AW-1:0] tk_run_avg;
	logic [CW:0]   tk_target;
	logic [7:0]    tk_streak;

	always_comb begin
		tk_us      = us_step[AW-1:AVG_SHIFT];
		tk_uf      = uf_step[AW-1:AVG_SHIFT];
		tk_ema     = (tk_us > tk_uf) ? tk_us : tk_uf;
		tk_run_avg = (longest_q != '0) ? run_step : run_avg_q;
		tk_target  = {1'b0, tk_ema} + {1'b0, tk_run_avg[AW-1:AVG_SHIFT]};
		tk_streak  = (streak_q != STREAK_MAX) ? (streak_q + 8'd1) : streak_q;
	end

	// Collect terms: surplus over the threshold, or the spurious share of the held pool.
	logic [CW-1:0] rc_us, rc_uf, rc_ema, rc_hs, rc_spur, rc_runa, rc_base;
	logic [CW-1:0] rc_over, rc_extra;
	logic [CW:0]   rc_ema2;
	logic [CW+1:0] rc_thr;
	logic          rc_above, rc_sp_on, rc_act;

	always_comb begin
		rc_us    = us_avg_q[AW-1:AVG_SHIFT];
		rc_uf    = uf_avg_q[AW-1:AVG_SHIFT];
		rc_ema   = (rc_us > rc_uf) ? rc_us : rc_uf;
		rc_ema2  = (used > rc_ema) ? {rc_ema, 1'b0} : {1'b0, rc_ema};
		rc_hs    = hs_avg_q[AW-1:AVG_SHIFT];
		rc_sp_on = (hf_avg_q >= hs_avg_q) || (held_q == rc_hs);
		rc_spur  = rc_sp_on ? (rc_hs >> 1) : '0;
		rc_runa  = run_avg_q[AW-1:AVG_SHIFT];
		rc_base  = (rc_runa > peak_q) ? rc_runa : peak_q;
		rc_thr   = {2'b00, rc_base} + {1'b0, rc_ema2};
		rc_above = {2'b00, alloc_q} > rc_thr;
		rc_over  = rc_above ? CW'({2'b00, alloc_q} - rc_thr) : '0;
		rc_extra = (rc_over > rc_spur) ? rc_over : rc_spur;
		if (rc_extra > held_q) begin
			rc_extra = held_q;
		end
		rc_act   = (held_q != '0) && (uf_avg_q <= us_avg_q) && (rc_above || (rc_spur != '0));
	end

	// Next state for the item in the input register.
	always_comb begin
		alloc_n   = alloc_q;
		held_n    = held_q;
		run_n     = run_q;
		longest_n = longest_q;
		peak_n    = peak_q;
		us_avg_n  = us_avg_q;
		uf_avg_n  = uf_avg_q;
		hs_avg_n  = hs_avg_q;
		hf_avg_n  = hf_avg_q;
		run_avg_n = run_avg_q;
		streak_n  = streak_q;
		gc_n      = gc_q;
		status_n  = STATUS_DONE;
		release_n = '0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (run_q != CNT_MAX) begin
					run_n = run_q + 1'b1;
				end
				if (held_q != '0) begin
					held_n   = held_q - 1'b1;
					status_n = STATUS_REUSED;
				end else if (alloc_q != CNT_MAX) begin
					alloc_n  = alloc_q + 1'b1;
					status_n = STATUS_NEW;
				end else begin
					status_n = STATUS_SAT;
				end
			end
			CMD_FREE: begin
				if (longest_q < run_q) begin
					longest_n = run_q;
				end
				run_n = '0;
				if (frag_s1) begin
					if (alloc_q > held_q) begin
						alloc_n = alloc_q - 1'b1;
					end
					status_n  = STATUS_FRAG;
					release_n = CW'(1);
				end else if (held_q != CNT_MAX) begin
					held_n = held_q + 1'b1;
					if (alloc_q < held_n) begin
						alloc_n = held_n;
					end
					status_n = STATUS_KEPT;
				end else begin
					status_n  = STATUS_SAT;
					release_n = CW'(1);
				end
			end
			CMD_TICK: begin
				us_avg_n  = us_step;
				uf_avg_n  = uf_step;
				hs_avg_n  = hs_step;
				hf_avg_n  = hf_step;
				run_avg_n = tk_run_avg;
				longest_n = '0;
				run_n     = '0;
				if ({1'b0, alloc_q} > tk_target) begin
					if (used > peak_q) begin
						peak_n = used;
					end
					streak_n = tk_streak;
					if (tk_streak >= limit_q) begin
						gc_n = 1'b1;
					end
				end else if ((hf_step >= hs_step) || (held_q >= (alloc_q >> HELD_SHARE_SHIFT))) begin
					gc_n = (alloc_q != '0);
				end else if (peak_q != '0) begin
					streak_n = '0;
					peak_n   = '0;
					gc_n     = 1'b0;
				end
			end
			CMD_COLLECT: begin
				if (gc_q) begin
					if (rc_act) begin
						held_n    = held_q - rc_extra;
						alloc_n   = (alloc_q >= rc_extra) ? (alloc_q - rc_extra) : '0;
						release_n = rc_extra;
					end
					streak_n = '0;
					peak_n   = '0;
					gc_n     = 1'b0;
				end
			end
			default: begin
				status_n = STATUS_DONE;
			end
		endcase
	end

	// Policy state and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q   <= '0;
			held_q    <= '0;
			run_q     <= '0;
			longest_q <= '0;
			peak_q    <= '0;
			us_avg_q  <= '0;
			uf_avg_q  <= '0;
			hs_avg_q  <= '0;
			hf_avg_q  <= '0;
			run_avg_q <= '0;
			streak_q  <= '0;
			gc_q      <= 1'b0;
			limit_q   <= OVERSIZE_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (start_s1) begin
				alloc_q   <= alloc_n;
				held_q    <= held_n;
				run_q     <= run_n;
				longest_q <= longest_n;
				peak_q    <= peak_n;
				us_avg_q  <= us_avg_n;
				uf_avg_q  <= uf_avg_n;
				hs_avg_q  <= hs_avg_n;
				hf_avg_q  <= hf_avg_n;
				run_avg_q <= run_avg_n;
				streak_q  <= streak_n;
				gc_q      <= gc_n;
			end
		end
	end

	// Result register.
	logic                done_s2;
	logic [2:0]          status_s2;
	logic [OUT_W-1:0]    release_s2, alloc_s2, held_s2;
	logic                gc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= start_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start_s1) begin
			status_s2  <= status_n;
			release_s2 <= OUT_W'(release_n);
			alloc_s2   <= OUT_W'(alloc_n);
			held_s2    <= OUT_W'(held_n);
			gc_s2      <= gc_n;
		end
	end

	assign done            = done_s2;
	assign status          = status_s2;
	assign release_count   = release_s2;
	assign allocated_count = alloc_s2;
	assign held_count      = held_s2;
	assign gc_wanted       = gc_s2;

endmodule

[rtl/bpsp_checker.sv]
// Port-level checker for the buffer pool sizing policy, bound to its top level.
`include "buffer_pool_sizing_policy_unit_assert.svh"

module bpsp_checker
	import bpsp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [2:0]        status,
	input logic [OUT_W-1:0]  release_count
);

	// Every accepted item is followed by done, after the input and result registers.
	`BPSP_ASSERT_NXT(a_item_latency, start && !busy, ##1 done)

	// A result is shown only for an item accepted before it.
	`BPSP_ASSERT_IMP(a_no_invented_item, done, $past(start, 2) && !$past(busy, 2))

	// Buffers are handed back only by a fragment, a saturated free or a collect.
	`BPSP_ASSERT_IMP(a_release_status, done && (release_count != '0),
		(status == STATUS_FRAG) || (status == STATUS_SAT) || (status == STATUS_DONE))

	// A released fragment hands back exactly one buffer.
	`BPSP_ASSERT_IMP(a_frag_release, done && (status == STATUS_FRAG), release_count == OUT_W'(1))

endmodule

bind buffer_pool_sizing_policy_unit bpsp_checker u_bpsp_checker (.*);

[tb/tb_buffer_pool_sizing_policy_unit.sv]
// Self-checking testbench for the buffer pool sizing policy unit: directed table, random episodes.
`timescale 1ns / 1ps

module tb_buffer_pool_sizing_policy_unit;
	import bpsp_pkg::*;

	localparam int AVG_SH = 5;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam int GAP_MAX = 18;
	localparam int MAX_SHOWN = 50;
	localparam int PHASE_ITEMS = 250;
	localparam int DIR_ROWS = 26;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] released;
		logic [15:0] allocated;
		logic [15:0] held;
		logic        gc;
	} pool_result_t;

	// One row of the directed table: either a limit write or a command item.
	typedef struct packed {
		bit           is_cfg;
		logic [7:0]   cfg_val;
		logic [1:0]   op;
		logic         frag;
		bit           typed;
		pool_result_t res;
	} stim_row_t;

	localparam pool_result_t NO_RES = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic        fragment;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        done;
	logic [2:0]  status;
	logic [15:0] release_count;
	logic [15:0] allocated_count;
	logic [15:0] held_count;
	logic        gc_wanted;

	// Hand-typed expectation that travels with the item being offered.
	logic         row_typed;
	pool_result_t row_res;

	// Pool state as the checker tracks it.
	logic [7:0]  limit_r;
	logic [15:0] alloc_r, held_r, run_len, longest_run, peak_r;
	logic [21:0] used_slow, used_fast, held_slow, held_fast, run_avg;
	logic [7:0]  streak;
	logic        gc_r;

	pool_result_t pending_results[$];
	int           mismatch_cnt;
	int           items_sent;
	bit           gaps_on;
	stim_row_t    dir_tab [DIR_ROWS];

	buffer_pool_sizing_policy_unit #(
		.COUNT_BITS(16),
		.AVG_SHIFT(AVG_SH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.fragment(fragment),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.release_count(release_count),
		.allocated_count(allocated_count),
		.held_count(held_count),
		.gc_wanted(gc_wanted)
	);

	always #10 clk = ~clk;

	// Exponential moving average step on a value scaled by 2^AVG_SH.
	function automatic logic [21:0] ema_update(logic [21:0] avg, int unsigned sample, int sh);
		return avg - (avg >> sh) + (sample >> sh);
	endfunction

	function automatic int unsigned max2(int unsigned a, int unsigned b);
		return a > b ? a : b;
	endfunction

	function automatic int unsigned used_now();
		return alloc_r > held_r ? 32'(alloc_r) - 32'(held_r) : 0;
	endfunction

	// Heartbeat: refresh the averages and decide whether collection is wanted.
	function automatic void run_tick();
		int unsigned used, ema;
		used = used_now();
		used_slow = ema_update(used_slow, used << AVG_SH, SLOW_SHIFT);
		used_fast = ema_update(used_fast, used << AVG_SH, FAST_SHIFT);
		ema = max2(32'(used_slow) >> AVG_SH, 32'(used_fast) >> AVG_SH);
		held_slow = ema_update(held_slow, 32'(held_r) << AVG_SH, SLOW_SHIFT);
		held_fast = ema_update(held_fast, 32'(held_r) << AVG_SH, FAST_SHIFT);
		if (longest_run != 0)
			run_avg = ema_update(run_avg, 32'(longest_run) << AVG_SH, FAST_SHIFT);
		longest_run = '0;
		run_len = '0;
		if (32'(alloc_r) > ema + (32'(run_avg) >> AVG_SH)) begin
			if (used > 32'(peak_r))
				peak_r = used[15:0];
			if (streak != STREAK_MAX)
				streak = streak + 8'd1;
			if (streak >= limit_r)
				gc_r = 1'b1;
		end else if (held_fast >= held_slow || held_r >= (alloc_r >> HELD_SHARE_SHIFT)) begin
			gc_r = (alloc_r != 0);
		end else if (peak_r != 0) begin
			streak = '0;
			peak_r = '0;
			gc_r = 1'b0;
		end
	endfunction

	// Collection: give back held buffers beyond what the averages justify.
	function automatic int unsigned reclaim_surplus();
		int unsigned ema, used, spur, thr, extra;
		spur = 0;
		extra = 0;
		if (held_r != 0 && used_fast <= used_slow) begin
			ema = max2(32'(used_slow) >> AVG_SH, 32'(used_fast) >> AVG_SH);
			used = used_now();
			if (used > ema)
				ema = ema * 2;
			if (held_fast >= held_slow || 32'(held_r) == (32'(held_slow) >> AVG_SH))
				spur = (32'(held_slow) >> AVG_SH) >> 1;
			thr = max2(32'(run_avg) >> AVG_SH, 32'(peak_r)) + ema;
			if (32'(alloc_r) > thr || spur != 0) begin
				// A threshold above the allocated count leaves no surplus.
				extra = 32'(alloc_r) > thr ? 32'(alloc_r) - thr : 0;
				extra = max2(extra, spur);
				if (extra > 32'(held_r))
					extra = 32'(held_r);
				held_r = held_r - extra[15:0];
				alloc_r = (32'(alloc_r) >= extra) ? alloc_r - extra[15:0] : '0;
			end
		end
		streak = '0;
		peak_r = '0;
		return extra;
	endfunction

	// Apply one command to the tracked pool and return the result it must produce.
	function automatic pool_result_t pool_step(logic [1:0] op, logic frag);
		pool_result_t r;
		r.status = STATUS_DONE;
		r.released = '0;
		case (op)
			CMD_ALLOC: begin
				if (run_len != CNT_MAX)
					run_len = run_len + 16'd1;
				if (held_r != 0) begin
					held_r = held_r - 16'd1;
					r.status = STATUS_REUSED;
				end else if (alloc_r != CNT_MAX) begin
					alloc_r = alloc_r + 16'd1;
					r.status = STATUS_NEW;
				end else begin
					r.status = STATUS_SAT;
				end
			end
			CMD_FREE: begin
				if (longest_run < run_len)
					longest_run = run_len;
				run_len = '0;
				if (frag) begin
					if (alloc_r > held_r)
						alloc_r = alloc_r - 16'd1;
					r.status = STATUS_FRAG;
					r.released = 16'd1;
				end else if (held_r != CNT_MAX) begin
					held_r = held_r + 16'd1;
					if (alloc_r < held_r)
						alloc_r = held_r;
					r.status = STATUS_KEPT;
				end else begin
					r.status = STATUS_SAT;
					r.released = 16'd1;
				end
			end
			CMD_TICK: begin
				run_tick();
			end
			CMD_COLLECT: begin
				if (gc_r) begin
					r.released = 16'(reclaim_surplus());
					gc_r = 1'b0;
				end
			end
		endcase
		r.allocated = alloc_r;
		r.held = held_r;
		r.gc = gc_r;
		return r;
	endfunction

	task automatic cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_SHOWN)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Track limit writes and accepted items, and check every result against the oldest one due.
	always @(posedge clk) begin
		pool_result_t calc, want;
		if (arst_n) begin
			if (cfg_we)
				limit_r = cfg_wdata;
			if (start && !busy) begin
				calc = pool_step(cmd, fragment);
				pending_results.push_back(row_typed ? row_res : calc);
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_SHOWN)
						$display("%0t: no result expected, got status %0d", $time, status);
				end else begin
					want = pending_results.pop_front();
					cmp_field("status", want.status, status);
					cmp_field("release_count", want.released, release_count);
					cmp_field("allocated_count", want.allocated, allocated_count);
					cmp_field("held_count", want.held, held_count);
					cmp_field("gc_wanted", want.gc, gc_wanted);
				end
			end
		end
	end

	// Offer one item, after a random gap when gaps are on, and hold it until the block takes it.
	task automatic send_item(logic [1:0] op, logic frag, bit typed = 1'b0,
			pool_result_t res = '0);
		int gap;
		gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		fragment <= frag;
		row_typed <= typed;
		row_res <= res;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Let every result come out, then write the oversize limit.
	task automatic write_limit(logic [7:0] val);
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random episode: mostly allocation bursts and frees followed by ticks and, usually, a collect.
	task automatic run_episode();
		int kind, n_alloc, n_free, frag_pct, n_tick;
		kind = $urandom_range(0, 9);
		gaps_on = ($urandom_range(0, 3) != 0);
		if (kind >= 8) begin
			repeat ($urandom_range(1, 20))
				send_item(2'($urandom_range(32'(CMD_ALLOC), 32'(CMD_COLLECT))),
					1'($urandom_range(0, 1)));
		end else begin
			n_alloc = $urandom_range(1, 24);
			n_free = $urandom_range(0, n_alloc + 4);
			// Episodes that keep every freed buffer build up a held surplus.
			frag_pct = (kind >= 6) ? 0 : $urandom_range(0, 60);
			while (n_alloc + n_free > 0) begin
				if (n_alloc > 0 && (n_free == 0 || $urandom_range(0, 99) < 65)) begin
					send_item(CMD_ALLOC, 1'($urandom_range(0, 1)));
					n_alloc--;
				end else begin
					send_item(CMD_FREE, $urandom_range(0, 99) < frag_pct);
					n_free--;
				end
			end
			n_tick = (kind >= 6) ? $urandom_range(5, 40) : $urandom_range(1, 4);
			repeat (n_tick)
				send_item(CMD_TICK, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0)
				send_item(CMD_COLLECT, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		logic [7:0] limit_set [6];
		int phase_end;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ALLOC;
		fragment = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		row_typed = 1'b0;
		row_res = NO_RES;
		limit_r = OVERSIZE_RESET;
		alloc_r = '0;
		held_r = '0;
		run_len = '0;
		longest_run = '0;
		peak_r = '0;
		used_slow = '0;
		used_fast = '0;
		held_slow = '0;
		held_fast = '0;
		run_avg = '0;
		streak = '0;
		gc_r = 1'b0;
		mismatch_cnt = 0;
		items_sent = 0;
		gaps_on = 1'b1;

		// The first rows start from reset with the default limit, so their results are typed in.
		dir_tab = '{
			'{1'b0, 8'd0, CMD_TICK, 1'b0, 1'b1, '{STATUS_DONE, 16'd0, 16'd0, 16'd0, 1'b0}},
			'{1'b0, 8'd0, CMD_COLLECT, 1'b1, 1'b1, '{STATUS_DONE, 16'd0, 16'd0, 16'd0, 1'b0}},
			'{1'b0, 8'd0, CMD_FREE, 1'b0, 1'b1, '{STATUS_KEPT, 16'd0, 16'd1, 16'd1, 1'b0}},
			'{1'b0, 8'd0, CMD_FREE, 1'b1, 1'b1, '{STATUS_FRAG, 16'd1, 16'd1, 16'd1, 1'b0}},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b0, 1'b1, '{STATUS_REUSED, 16'd0, 16'd1, 16'd0, 1'b0}},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b0, 1'b1, '{STATUS_NEW, 16'd0, 16'd2, 16'd0, 1'b0}},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b1, 1'b1, '{STATUS_NEW, 16'd0, 16'd3, 16'd0, 1'b0}},
			'{1'b0, 8'd0, CMD_FREE, 1'b1, 1'b1, '{STATUS_FRAG, 16'd1, 16'd2, 16'd0, 1'b0}},
			'{1'b0, 8'd0, CMD_TICK, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_COLLECT, 1'b0, 1'b0, NO_RES},
			'{1'b1, 8'd0, CMD_ALLOC, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b1, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_ALLOC, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_FREE, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_TICK, 1'b1, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_COLLECT, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_FREE, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_FREE, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_TICK, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_TICK, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_COLLECT, 1'b1, 1'b0, NO_RES},
			'{1'b1, 8'd255, CMD_ALLOC, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_TICK, 1'b0, 1'b0, NO_RES},
			'{1'b0, 8'd0, CMD_COLLECT, 1'b0, 1'b0, NO_RES}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, including a zero limit so the first tick above target asks for collection.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_limit(dir_tab[i].cfg_val);
			else
				send_item(dir_tab[i].op, dir_tab[i].frag, dir_tab[i].typed, dir_tab[i].res);
		end

		// Random phases over several limits, 1 and 255 among them.
		limit_set = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)), OVERSIZE_RESET, 8'd5};
		foreach (limit_set[p]) begin
			write_limit(limit_set[p]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				run_episode();
		end

		// Closing mix: ticks, a fragment, collects and a short allocation burst.
		write_limit(8'd3);
		gaps_on = 1'b1;
		repeat (4) send_item(CMD_TICK, 1'b0);
		send_item(CMD_FREE, 1'b1);
		send_item(CMD_COLLECT, 1'b0);
		repeat (3) send_item(CMD_TICK, 1'b1);
		send_item(CMD_COLLECT, 1'b1);
		repeat (4) send_item(CMD_ALLOC, 1'b0);
		send_item(CMD_TICK, 1'b0);

		// Drain and let the pipeline settle before the verdict.
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[buffer_pool_sizing_policy_unit.f]
+incdir+rtl
rtl/bpsp_pkg.sv
rtl/bpsp_ema.sv
rtl/buffer_pool_sizing_policy_unit.sv
rtl/bpsp_checker.sv
tb/tb_buffer_pool_sizing_policy_unit.sv
